/* rtl/core/kot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword/operator tokenizer package
// Shared types, constants and helper functions of the tokenizer.
// ----------------------------------------------------------------------------
package kot_pkg;

  localparam int unsigned MAX_WORD_CHARS = 8;
  localparam int unsigned COUNTER_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_KEYWORDS   = 10;

  localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;
  localparam logic [7:0]              LENGTH_MAX  = 8'hFF;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic {
    REQ_CHAR = 1'b0,
    REQ_END  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_KEYWORD  = 2'd0,
    KIND_IDENT    = 2'd1,
    KIND_OPERATOR = 2'd2
  } token_kind_e;

  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] char_byte;
  } in_req_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [63:0] token_text;
    logic [7:0]  token_length;
    logic        truncated;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_out_t;

  localparam logic [NUM_KEYWORDS-1:0][63:0] KW_TEXT = {
    64'h0000_0000_6469_6f76,  // void
    64'h0000_656c_6275_6f64,  // double
    64'h0000_0000_0074_6e69,  // int
    64'h0000_0073_7361_6c63,  // class
    64'h0000_0000_0066_6564,  // def
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0000_0072_6f66,  // for
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0000_0000_6669   // if
  };

  localparam logic [NUM_KEYWORDS-1:0][7:0] KW_LEN = {
    8'd4, 8'd6, 8'd3, 8'd5, 8'd3, 8'd6, 8'd5, 8'd3, 8'd4, 8'd2
  };

  function automatic logic kw_hit(logic [63:0] text, logic [7:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (len == KW_LEN[k] && text == KW_TEXT[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [15:0] sat16(logic [COUNTER_BITS-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic logic [COUNTER_BITS-1:0] bump(logic [COUNTER_BITS-1:0] cnt);
    return (cnt != COUNTER_MAX) ? cnt + 1'b1 : cnt;
  endfunction

endpackage

/* rtl/core/kot_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scan stage
// Holds the word buffer and position counters and forms up to two tokens
// for each accepted request.
// ----------------------------------------------------------------------------
module kot_scan import kot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_req_t   req_i,
  output scan_out_t scan_o
);

  logic [63:0]             buf_q, buf_d;
  logic [7:0]              len_q, len_d;
  logic [COUNTER_BITS-1:0] line_q, line_d;
  logic [COUNTER_BITS-1:0] col_q, col_d;

  token_t word_tok, op_tok;
  logic   have_word;
  logic   is_op;

  always_comb begin
    have_word = (len_q != 8'd0);
    is_op = req_i.char_byte inside {"+", "-", "*", "/", "(", ")", "{", "}",
                                    "[", "]", ",", ";", "=", "<", ">", ":"};

    word_tok.token_kind    = (len_q <= 8'(MAX_WORD_CHARS) && kw_hit(buf_q, len_q))
                             ? KIND_KEYWORD : KIND_IDENT;
    word_tok.token_text    = buf_q;
    word_tok.token_length  = len_q;
    word_tok.truncated     = (len_q > 8'(MAX_WORD_CHARS));
    word_tok.line_number   = sat16(line_q);
    word_tok.column_number = sat16(col_q);
    word_tok.last_of_run   = 1'b1;

    op_tok.token_kind    = KIND_OPERATOR;
    op_tok.token_text    = 64'(req_i.char_byte);
    op_tok.token_length  = 8'd1;
    op_tok.truncated     = 1'b0;
    op_tok.line_number   = sat16(line_q);
    op_tok.column_number = sat16(col_q);
    op_tok.last_of_run   = 1'b1;
  end

  always_comb begin
    scan_o.count = 2'd0;
    scan_o.tok0  = word_tok;
    scan_o.tok1  = op_tok;
    buf_d  = buf_q;
    len_d  = len_q;
    line_d = line_q;
    col_d  = col_q;

    if (req_i.req_type == REQ_END) begin
      scan_o.count = {1'b0, have_word};
      buf_d  = '0;
      len_d  = '0;
      line_d = COUNTER_BITS'(1);
      col_d  = '0;
    end else if (req_i.char_byte == CH_NEWLINE) begin
      scan_o.count = {1'b0, have_word};
      buf_d  = '0;
      len_d  = '0;
      line_d = bump(line_q);
      col_d  = '0;
    end else if (req_i.char_byte == CH_SPACE || req_i.char_byte == CH_TAB) begin
      scan_o.count = {1'b0, have_word};
      buf_d  = '0;
      len_d  = '0;
      col_d  = bump(col_q);
    end else if (is_op) begin
      if (have_word) begin
        scan_o.count = 2'd2;
        scan_o.tok0.last_of_run = 1'b0;
      end else begin
        scan_o.count = 2'd1;
        scan_o.tok0  = op_tok;
      end
      buf_d  = '0;
      len_d  = '0;
      col_d  = bump(col_q);
    end else begin
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        if (len_q == 8'(i)) begin
          buf_d[i*8 +: 8] = req_i.char_byte;
        end
      end
      if (len_q != LENGTH_MAX) begin
        len_d = len_q + 8'd1;
      end
      col_d = bump(col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      len_q  <= '0;
      line_q <= COUNTER_BITS'(1);
      col_q  <= '0;
    end else if (accept_i) begin
      buf_q  <= buf_d;
      len_q  <= len_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

/* rtl/core/keyword_operator_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword/operator tokenizer
// Splits a byte stream into keyword, identifier and operator tokens.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one source byte or an end of
// text marker. A request is taken when in_valid_i and in_ready_o are both
// high. Each request yields zero, one or two tokens on the output channel,
// which is taken when out_valid_o and out_ready_i are both high.
// The scan state is updated in the cycle a request is taken, and its tokens
// are written into a four-entry result queue. The tokens of a request are
// registered in the queue when the request is taken. The block takes one
// request per cycle while the queue has room for two more tokens; the
// sustained rate is therefore one request per cycle as long as requests
// produce at most one token on average, and otherwise is set by the
// one-token-per-cycle output port.
// When the receiver stalls, the queue fills and in_ready_o falls; no token
// is lost or dropped. Reset empties the queue, clears the pending word and
// sets the line counter to one and the column counter to zero.
// ----------------------------------------------------------------------------
module keyword_operator_tokenizer import kot_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output token_t  out_tok_o
);

  token_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                accept;
  logic                pop;
  logic [1:0]          push;
  scan_out_t           scan;

  assign in_ready_o  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_tok_o   = queue_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push        = accept ? scan.count : 2'd0;

  kot_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .scan_o   (scan)
  );

  always_comb begin
    wptr_d  = wptr_q + QPTR_W'(push);
    rptr_d  = rptr_q + QPTR_W'(pop);
    count_d = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push != 2'd0) begin
      queue_q[wptr_q] <= scan.tok0;
    end
    if (push == 2'd2) begin
      queue_q[wptr_q + QPTR_W'(1)] <= scan.tok1;
    end
  end

endmodule

/* rtl/core/kot_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Checks handshake and token properties visible on the ports of the tokenizer.
// ----------------------------------------------------------------------------
module kot_checker import kot_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input in_req_t in_req_i,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input token_t  out_tok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output request dropped while stalled.");

  a_op_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tok_o.token_kind == KIND_OPERATOR |->
      out_tok_o.token_length == 8'd1 && !out_tok_o.truncated && out_tok_o.last_of_run)
    else $error("Operator token has a bad shape.");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_tok_o.token_length != 8'd0 && out_tok_o.line_number != 16'd0)
    else $error("Token with zero length or zero line.");

  a_trunc_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tok_o.truncated |->
      out_tok_o.token_kind == KIND_IDENT && out_tok_o.token_length > 8'(MAX_WORD_CHARS))
    else $error("Truncated token is not a long identifier.");

endmodule

bind keyword_operator_tokenizer kot_checker u_kot_checker (.*);
